>>> rtl/core/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants of the search transposition table: table
// geometry, bound codes, request codes and the request and response words.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Table geometry; the slot count is a power of two so the slot index is the
  // low bits of the hash.
  localparam int TABLE_ENTRIES = 65536;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int KEY_BITS      = 16;
  localparam int MOVE_BITS     = 16;
  localparam int OCC_SLOTS     = 1000;

  localparam logic [14:0] MATE_THR_RESET = 15'd30000;

  // Request codes
  localparam logic [1:0] REQ_PROBE = 2'd0;
  localparam logic [1:0] REQ_STORE = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    BOUND_EMPTY = 2'd0,
    BOUND_EXACT = 2'd1,
    BOUND_LOWER = 2'd2,
    BOUND_UPPER = 2'd3
  } bound_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [63:0]        hash;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic signed [15:0] old_alpha;
    logic [7:0]         depth;
    logic [7:0]         ply;
    logic [15:0]        best_move;
    logic signed [15:0] best_score;
  } stt_req_t;

  typedef struct packed {
    logic               hit;
    logic [1:0]         entry_bound;
    logic [7:0]         entry_depth;
    logic [15:0]        entry_move;
    logic signed [15:0] entry_score;
    logic               cutoff_possible;
    logic [9:0]         occupancy;
  } stt_rsp_t;

endpackage

>>> rtl/core/stt_req_if.sv
// ----------------------------------------------------------------------------
// stt_req_if
// Request channel of the transposition table: valid, ready and a request word.
// ----------------------------------------------------------------------------
interface stt_req_if
  import stt_pkg::*;
();
  logic     valid;
  logic     ready;
  stt_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/stt_rsp_if.sv
// ----------------------------------------------------------------------------
// stt_rsp_if
// Response channel of the transposition table: valid, ready and a result word.
// ----------------------------------------------------------------------------
interface stt_rsp_if
  import stt_pkg::*;
();
  logic     valid;
  logic     ready;
  stt_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/search_transposition_table.sv
// ----------------------------------------------------------------------------
// search_transposition_table
// Direct-mapped, always-replace transposition table with probe, store and
// clear requests.
// ----------------------------------------------------------------------------
// For a probe or a store the word is accepted and the slot is read from the
// synchronous table memory, then the result is formed and, for a store, the
// slot is written back; a new word is accepted the cycle after. A clear
// writes one slot per cycle over the whole table, then forms the result word,
// and a new word is accepted the cycle after. After reset a clearing pass over
// all TABLE_ENTRIES slots (65536) zeroes the table while no request is
// accepted; the mate threshold may be written meanwhile.
// The table sits in two memories: bound, key and move in one, which a clear
// wipes, and depth and score in the other, which a clear leaves alone. One
// result word waits in an output register; a new request is still accepted
// while it waits, but its result, and a store's write-back, hold until the
// waiting word leaves.
// ----------------------------------------------------------------------------
module search_transposition_table
  import stt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [14:0]  cfg_wdata_i,
  stt_req_if.sink      req_i,
  stt_rsp_if.source    rsp_o
);

  typedef struct packed {
    bound_e               bound;
    logic [KEY_BITS-1:0]  key;
    logic [MOVE_BITS-1:0] move;
  } tag_entry_t;

  typedef struct packed {
    logic [7:0]         depth;
    logic signed [15:0] score;
  } val_entry_t;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_CLEAR
  } state_e;

  localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(TABLE_ENTRIES - 1);
  localparam logic [IDX_BITS-1:0] IDX_OCC  = IDX_BITS'(OCC_SLOTS);

  state_e              state_q;
  logic [IDX_BITS-1:0] ptr_q;
  logic [9:0]          occ_q, occ_d;
  logic [14:0]         mate_thr_q;
  logic                rsp_valid_q, rsp_valid_d;
  stt_rsp_t            rsp_q, rsp_d;
  stt_req_t            req_q;

  tag_entry_t          tag_mem_q [TABLE_ENTRIES];
  val_entry_t          val_mem_q [TABLE_ENTRIES];
  tag_entry_t          tag_rd_q;
  val_entry_t          val_rd_q;

  logic                accept;
  logic                out_free;
  logic                rd_en;
  logic [IDX_BITS-1:0] rd_addr;
  logic                tag_we, val_we;
  logic [IDX_BITS-1:0] wr_addr;
  tag_entry_t          tag_wd;
  val_entry_t          val_wd;
  logic [IDX_BITS-1:0] req_idx;
  logic signed [15:0]  probe_score;
  logic                probe_hit;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  // Move a mate score by ply; away from the root when dir_in, else back.
  function automatic logic signed [15:0] mate_adj(input logic signed [15:0] s,
                                                  input logic [7:0] ply,
                                                  input logic [14:0] thr,
                                                  input logic dir_in);
    logic signed [17:0] s18;
    logic signed [17:0] t18;
    logic signed [17:0] p18;
    s18 = 18'(s);
    t18 = signed'({3'b000, thr});
    p18 = signed'({10'd0, ply});
    if (s18 >= t18) begin
      return dir_in ? sat16(s18 + p18) : sat16(s18 - p18);
    end else if (s18 <= -t18) begin
      return dir_in ? sat16(s18 - p18) : sat16(s18 + p18);
    end else begin
      return s;
    end
  endfunction

  assign req_i.ready   = (state_q == S_IDLE);
  assign accept        = req_i.valid && req_i.ready;
  assign out_free      = !rsp_valid_q || rsp_o.ready;
  assign rd_en         = accept;
  assign rd_addr       = req_i.payload.hash[IDX_BITS-1:0];
  assign req_idx       = req_q.hash[IDX_BITS-1:0];
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  always_comb begin
    probe_hit   = (tag_rd_q.key == req_q.hash[KEY_BITS-1:0])
                  && (tag_rd_q.bound != BOUND_EMPTY);
    probe_score = mate_adj(val_rd_q.score, req_q.ply, mate_thr_q, 1'b0);

    rsp_d           = '0;
    rsp_valid_d     = rsp_valid_q && !rsp_o.ready;
    occ_d           = occ_q;
    tag_we          = 1'b0;
    val_we          = 1'b0;
    wr_addr         = req_idx;
    tag_wd          = '0;
    val_wd          = '0;

    case (state_q)
      S_INIT: begin
        tag_we  = 1'b1;
        val_we  = 1'b1;
        wr_addr = ptr_q;
      end
      S_CLEAR: begin
        tag_we  = 1'b1;
        wr_addr = ptr_q;
      end
      S_EXEC: begin
        case (req_q.req_type)
          REQ_PROBE: begin
            rsp_d.hit         = probe_hit;
            rsp_d.entry_bound = tag_rd_q.bound;
            rsp_d.entry_depth = val_rd_q.depth;
            rsp_d.entry_move  = 16'(tag_rd_q.move);
            rsp_d.entry_score = probe_score;
            if (probe_hit && (val_rd_q.depth >= req_q.depth)) begin
              case (tag_rd_q.bound)
                BOUND_EXACT: rsp_d.cutoff_possible = 1'b1;
                BOUND_LOWER: rsp_d.cutoff_possible = (probe_score >= req_q.beta);
                BOUND_UPPER: rsp_d.cutoff_possible = (probe_score <= req_q.alpha);
                default:     rsp_d.cutoff_possible = 1'b0;
              endcase
            end
          end
          REQ_STORE: begin
            if (req_q.best_score >= req_q.beta) begin
              tag_wd.bound = BOUND_LOWER;
            end else if (req_q.alpha != req_q.old_alpha) begin
              tag_wd.bound = BOUND_EXACT;
            end else begin
              tag_wd.bound = BOUND_UPPER;
            end
            tag_wd.key   = req_q.hash[KEY_BITS-1:0];
            tag_wd.move  = MOVE_BITS'(req_q.best_move);
            val_wd.depth = req_q.depth;
            val_wd.score = mate_adj(req_q.best_score, req_q.ply, mate_thr_q, 1'b1);
            if ((req_idx < IDX_OCC) && (tag_rd_q.bound == BOUND_EMPTY)) begin
              occ_d = occ_q + 10'd1;
            end
            // write back only when the output register is free to take the result word
            tag_we = out_free;
            val_we = out_free;
          end
          default: begin
          end
        endcase
        rsp_d.occupancy = occ_d;
        if (out_free) begin
          rsp_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ptr_q       <= '0;
      occ_q       <= '0;
      mate_thr_q  <= MATE_THR_RESET;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        mate_thr_q <= cfg_wdata_i;
      end
      rsp_valid_q <= rsp_valid_d;
      case (state_q)
        S_INIT: begin
          ptr_q <= ptr_q + IDX_BITS'(1);
          if (ptr_q == IDX_LAST) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (req_i.payload.req_type == REQ_CLEAR) begin
              occ_q   <= '0;
              state_q <= S_CLEAR;
            end else begin
              state_q <= S_EXEC;
            end
          end
        end
        S_CLEAR: begin
          // pointer wraps back to zero on the last slot
          ptr_q <= ptr_q + IDX_BITS'(1);
          if (ptr_q == IDX_LAST) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            rsp_q       <= rsp_d;
            occ_q       <= occ_d;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the accepted request word for the execute step
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i.payload;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem_q[wr_addr] <= tag_wd;
    end
    if (rd_en) begin
      tag_rd_q <= tag_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem_q[wr_addr] <= val_wd;
    end
    if (rd_en) begin
      val_rd_q <= val_mem_q[rd_addr];
    end
  end

endmodule

>>> test/stt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_checker
// Watches the request and response channels of the transposition table. It
// keeps its own copy of the slots, the occupancy count and the mate
// threshold, works out the response to every accepted request word and
// compares each accepted response word with the oldest one still waiting.
// ----------------------------------------------------------------------------
module stt_checker
  import stt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,
  stt_req_if          req_mon,
  stt_rsp_if          rsp_mon,
  output int          fail_count_o,
  output int          outstanding_o
);

  // Slot contents; two-state arrays start at zero, as the table does.
  bit [1:0]           slot_bound [TABLE_ENTRIES];
  bit [KEY_BITS-1:0]  slot_key   [TABLE_ENTRIES];
  bit [7:0]           slot_depth [TABLE_ENTRIES];
  bit [MOVE_BITS-1:0] slot_move  [TABLE_ENTRIES];
  bit signed [15:0]   slot_score [TABLE_ENTRIES];

  int unsigned occupied = 0;
  bit [14:0]   mate_thr = MATE_THR_RESET;
  stt_rsp_t    waiting_rsp [$];
  int          fails = 0;
  int          waiting = 0;

  assign fail_count_o  = fails;
  assign outstanding_o = waiting;

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Mate scores grow by ply on the way into the table ...
  function automatic int mate_push(int s, int ply);
    int t;
    t = int'(mate_thr);
    if (s >= t) return sat16(s + ply);
    if (s <= -t) return sat16(s - ply);
    return s;
  endfunction

  // ... and shrink by ply on the way out.
  function automatic int mate_pull(int s, int ply);
    int t;
    t = int'(mate_thr);
    if (s >= t) return sat16(s - ply);
    if (s <= -t) return sat16(s + ply);
    return s;
  endfunction

  function automatic stt_rsp_t table_response(stt_req_t w);
    stt_rsp_t r;
    int       idx;
    int       a;
    int       b;
    int       oa;
    int       best;
    int       ply;
    int       sc;
    bit [1:0] nb;
    r    = '0;
    idx  = int'(w.hash[IDX_BITS-1:0]);
    a    = int'($signed(w.alpha));
    b    = int'($signed(w.beta));
    oa   = int'($signed(w.old_alpha));
    best = int'($signed(w.best_score));
    ply  = int'(w.ply);
    case (w.req_type)
      REQ_PROBE: begin
        r.hit = (slot_bound[idx] != BOUND_EMPTY) &&
                (slot_key[idx] == w.hash[KEY_BITS-1:0]);
        sc = mate_pull(slot_score[idx], ply);
        r.entry_bound = slot_bound[idx];
        r.entry_depth = slot_depth[idx];
        r.entry_move  = slot_move[idx];
        r.entry_score = sc[15:0];
        if (r.hit && slot_depth[idx] >= w.depth) begin
          case (slot_bound[idx])
            BOUND_EXACT: r.cutoff_possible = 1'b1;
            BOUND_LOWER: r.cutoff_possible = (sc >= b);
            BOUND_UPPER: r.cutoff_possible = (sc <= a);
            default:     r.cutoff_possible = 1'b0;
          endcase
        end
      end
      REQ_STORE: begin
        if (best >= b) nb = BOUND_LOWER;
        else if (a != oa) nb = BOUND_EXACT;
        else nb = BOUND_UPPER;
        if (idx < OCC_SLOTS && slot_bound[idx] == BOUND_EMPTY) occupied++;
        sc = mate_push(best, ply);
        slot_bound[idx] = nb;
        slot_key[idx]   = w.hash[KEY_BITS-1:0];
        slot_depth[idx] = w.depth;
        slot_move[idx]  = w.best_move[MOVE_BITS-1:0];
        slot_score[idx] = sc[15:0];
      end
      REQ_CLEAR: begin
        // Depth and score survive a clear.
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          slot_bound[i] = BOUND_EMPTY;
          slot_key[i]   = '0;
          slot_move[i]  = '0;
        end
        occupied = 0;
      end
      default: ;
    endcase
    r.occupancy = occupied[9:0];
    return r;
  endfunction

  task automatic note_mismatch(string field, logic signed [31:0] exp_v,
                               logic signed [31:0] act_v);
    fails++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
  endtask

  always @(posedge clk_i) begin : monitor
    stt_rsp_t want;
    stt_rsp_t got;
    if (rst_ni) begin
      if (cfg_we_i) mate_thr = cfg_wdata_i;
      // Responses at this edge belong to earlier requests: pop before push.
      if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
        got = rsp_mon.payload;
        if (waiting_rsp.size() == 0) begin
          fails++;
          $display("%0t: response word with none expected, expected none, actual occupancy %0d",
                   $time, got.occupancy);
        end else begin
          want = waiting_rsp.pop_front();
          if (got.hit !== want.hit)
            note_mismatch("hit", 32'(want.hit), 32'(got.hit));
          if (got.entry_bound !== want.entry_bound)
            note_mismatch("entry_bound", 32'(want.entry_bound), 32'(got.entry_bound));
          if (got.entry_depth !== want.entry_depth)
            note_mismatch("entry_depth", 32'(want.entry_depth), 32'(got.entry_depth));
          if (got.entry_move !== want.entry_move)
            note_mismatch("entry_move", 32'(want.entry_move), 32'(got.entry_move));
          if (got.entry_score !== want.entry_score)
            note_mismatch("entry_score", 32'(want.entry_score), 32'(got.entry_score));
          if (got.cutoff_possible !== want.cutoff_possible)
            note_mismatch("cutoff_possible", 32'(want.cutoff_possible),
                          32'(got.cutoff_possible));
          if (got.occupancy !== want.occupancy)
            note_mismatch("occupancy", 32'(want.occupancy), 32'(got.occupancy));
        end
      end
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
        waiting_rsp.push_back(table_response(req_mon.payload));
      waiting = waiting_rsp.size();
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the transposition table: a short directed run over the score
// extremes, mate saturation, every bound kind and the clear, then phases
// under several mate thresholds with a table fill and random store/probe
// traffic, random gaps on both channels, and the verdict.
// ----------------------------------------------------------------------------
module tb;
  import stt_pkg::*;

  localparam logic [1:0] REQ_SPARE    = 2'd3;
  localparam int         RUN_LIMIT_NS = 40_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [14:0] cfg_wdata;

  stt_req_if req_if ();
  stt_rsp_if rsp_if ();

  int fail_count;
  int outstanding;
  bit quiet = 1'b0;
  bit valid_up = 1'b0;
  int stall_left = 0;
  int thr = 30000;

  search_transposition_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  stt_checker check_u (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .req_mon       (req_if),
    .rsp_mon       (rsp_if),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Scores cluster round the mate threshold and the 16-bit extremes.
  function automatic logic signed [15:0] pick_score();
    int v;
    case ($urandom_range(0, 5))
      0:       v = int'($urandom);
      1:       v = thr + int'($urandom_range(0, 6)) - 3;
      2:       v = -thr + int'($urandom_range(0, 6)) - 3;
      3:       v = 32767 - int'($urandom_range(0, 3));
      4:       v = -32768 + int'($urandom_range(0, 3));
      default: v = int'($urandom_range(0, 600)) - 300;
    endcase
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_slot();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(0, 15));
    if (r == 6) return 16'($urandom_range(990, 1010));
    if (r == 7) return 16'(65535 - $urandom_range(0, 3));
    return 16'($urandom);
  endfunction

  function automatic stt_req_t make_word(logic [1:0] kind, logic [15:0] slot);
    stt_req_t w;
    int       v;
    w.req_type   = kind;
    w.hash       = {$urandom, $urandom};
    w.hash[15:0] = slot;
    w.best_score = pick_score();
    w.alpha      = pick_score();
    w.beta       = pick_score();
    if ($urandom_range(0, 2) == 0) begin
      v = int'(w.best_score) + int'($urandom_range(0, 4)) - 2;
      w.beta = v[15:0];
    end
    w.old_alpha = $urandom_range(0, 1) ? w.alpha : pick_score();
    w.depth     = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    w.ply       = 8'($urandom);
    w.best_move = 16'($urandom);
    return w;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance, or later when a random gap follows.
  task automatic send_word(stt_req_t w);
    int gap;
    req_if.valid   <= 1'b1;
    req_if.payload <= w;
    valid_up = 1'b1;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      valid_up = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_fields(input logic [1:0] kind, input logic [63:0] hash,
                             input int a, input int b, input int oa, input int d,
                             input int p, input int mv, input int sc);
    stt_req_t w;
    w.req_type   = kind;
    w.hash       = hash;
    w.alpha      = 16'(a);
    w.beta       = 16'(b);
    w.old_alpha  = 16'(oa);
    w.depth      = 8'(d);
    w.ply        = 8'(p);
    w.best_move  = 16'(mv);
    w.best_score = 16'(sc);
    send_word(w);
  endtask

  // Hold off the sender until every response word has come back.
  task automatic drain();
    if (valid_up) begin
      req_if.valid <= 1'b0;
      valid_up = 1'b0;
    end
    while (outstanding != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_threshold(int v);
    cfg_we    <= 1'b1;
    cfg_wdata <= 15'(v);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    thr = v;
  endtask

  task automatic run_random(int count, bit with_clear);
    int       clear_at;
    int       r;
    logic [15:0] slot;
    stt_req_t w;
    stt_req_t w2;
    clear_at = with_clear ? $urandom_range(count / 4, 3 * count / 4) : -1;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n == clear_at) send_word(make_word(REQ_CLEAR, pick_slot()));
      r = $urandom_range(0, 99);
      if (r < 40) begin
        // Store then probe the same slot, mostly at the same ply.
        slot = pick_slot();
        w = make_word(REQ_STORE, slot);
        send_word(w);
        w2 = make_word(REQ_PROBE, slot);
        if ($urandom_range(0, 3) != 0) w2.ply = w.ply;
        send_word(w2);
        n++;
      end else if (r < 70) begin
        send_word(make_word(REQ_PROBE, pick_slot()));
      end else if (r < 95) begin
        send_word(make_word(REQ_STORE, pick_slot()));
      end else if (r < 98) begin
        send_word(make_word(REQ_SPARE, pick_slot()));
      end else begin
        drain();
      end
    end
    quiet = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_if.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty table, saturating mate scores, each bound kind
    send_fields(REQ_PROBE, 64'h0, 0, 0, 0, 0, 0, 0, 0);
    send_fields(REQ_STORE, 64'h0, -32768, -32768, -32768, 255, 255, 16'hFFFF, 32767);
    send_fields(REQ_PROBE, 64'h0, 32767, -32768, 0, 255, 255, 0, 0);
    send_fields(REQ_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 32767, 0, 0, 255, 0, -32768);
    send_fields(REQ_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 32767, 32767, 0, 0, 0, 0, 0);
    send_fields(REQ_STORE, 64'd999, 5, 100, -5, 10, 3, 16'h1234, 0);
    send_fields(REQ_STORE, 64'd1000, 0, 0, 0, 20, 0, 16'h00FF, -1);
    send_fields(REQ_PROBE, 64'd999, 0, 0, 0, 0, 3, 0, 0);
    send_fields(REQ_PROBE, 64'd1000, 0, 0, 0, 255, 0, 0, 0);
    // Overwrite an occupied slot with a score right at the threshold
    send_fields(REQ_STORE, 64'h0, 0, 30000, 0, 7, 1, 16'h8001, 30000);
    send_fields(REQ_PROBE, 64'h0, 0, 30000, 0, 7, 1, 0, 0);
    send_fields(REQ_STORE, 64'd1, 0, 0, 0, 4, 5, 16'h0042, -30000);
    send_fields(REQ_PROBE, 64'd1, -30000, 0, 0, 4, 5, 0, 0);
    send_fields(REQ_SPARE, 64'd1, 0, 0, 0, 0, 0, 16'hFFFF, 100);
    send_fields(REQ_PROBE, 64'd5, 0, 0, 0, 0, 0, 0, 0);
    send_fields(REQ_CLEAR, 64'h0, 0, 0, 0, 0, 0, 0, 0);
    // After a clear the depth and score of a slot remain visible
    send_fields(REQ_PROBE, 64'h0, 0, 0, 0, 0, 9, 0, 0);
    send_fields(REQ_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
    drain();
    // Zero threshold: a score of zero counts as a positive mate score
    write_threshold(0);
    send_fields(REQ_STORE, 64'd3, 0, 1, 0, 2, 7, 16'h0003, 0);
    send_fields(REQ_STORE, 64'd4, 0, 1, 0, 2, 10, 16'h0004, -1);
    send_fields(REQ_PROBE, 64'd3, 0, 1, 0, 0, 2, 0, 0);
    send_fields(REQ_PROBE, 64'd4, 0, 1, 0, 0, 2, 0, 0);
    drain();

    // Fill the counted slots so the occupancy reaches its top
    write_threshold(30000);
    for (int s = 0; s < OCC_SLOTS; s++) begin
      quiet = (s < 400);
      send_word(make_word(REQ_STORE, 16'(s)));
    end
    quiet = 1'b0;
    run_random(100, 1'b0);
    drain();

    write_threshold(0);
    run_random(240, 1'b1);
    drain();

    write_threshold(32767);
    run_random(120, 1'b0);
    drain();
    run_random(120, 1'b0);
    drain();

    write_threshold($urandom_range(1, 32766));
    run_random(240, 1'b1);
    drain();

    write_threshold($urandom_range(1, 300));
    run_random(180, 1'b0);
    drain();
    repeat (20) @(negedge clk_i);

    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
